FILE: hw/rtl/fled_pkg.sv
// ----------------------------------------------------------------------------
// Fuel level event detector package
// Shared constants, register codes, event codes and result types.
// ----------------------------------------------------------------------------
package fled_pkg;

  // Width of the level fields on the ports (unsigned Q12.4).
  localparam int unsigned PORT_W    = 16;
  // Extra fraction bits kept on the mean and the smoothed level.
  localparam int unsigned FRAC_W    = 16;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 8;
  // Signed width of the threshold compares: threshold and level difference
  // both fit in 33 signed bits, one more keeps the negation of the
  // difference safe.
  localparam int unsigned CMP_W     = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_THR = 8'd0,
    REG_RISE_HYS = 8'd1,
    REG_FALL_THR = 8'd2,
    REG_FALL_HYS = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEGIN = 2'd1,
    EV_END   = 2'd2
  } event_e;

  localparam logic [PORT_W-1:0] RISE_THR_RST = 16'd320;
  localparam logic [PORT_W-1:0] RISE_HYS_RST = 16'd160;
  localparam logic [PORT_W-1:0] FALL_THR_RST = 16'd320;
  localparam logic [PORT_W-1:0] FALL_HYS_RST = 16'd160;

  typedef struct packed {
    logic [PORT_W-1:0] rise_thr;
    logic [PORT_W-1:0] rise_hys;
    logic [PORT_W-1:0] fall_thr;
    logic [PORT_W-1:0] fall_hys;
  } thresh_t;

  typedef struct packed {
    logic [PORT_W-1:0] mean_level;
    logic [PORT_W-1:0] smoothed_level;
    event_e            refuel_event;
    event_e            drain_event;
    logic              refuelling_active;
    logic              draining_active;
  } result_t;

endpackage

FILE: hw/rtl/fled_in_if.sv
// ----------------------------------------------------------------------------
// Fuel level sample channel
// Valid/ready channel that carries one fuel level sample per item.
// ----------------------------------------------------------------------------
interface fled_in_if;
  logic                       valid;
  logic                       ready;
  logic [fled_pkg::PORT_W-1:0] tank_level;

  modport source (output valid, output tank_level, input ready);
  modport sink   (input valid, input tank_level, output ready);
endinterface

FILE: hw/rtl/fled_out_if.sv
// ----------------------------------------------------------------------------
// Fuel level result channel
// Valid/ready channel that carries levels, event codes and state flags.
// ----------------------------------------------------------------------------
interface fled_out_if;
  logic                        valid;
  logic                        ready;
  logic [fled_pkg::PORT_W-1:0] mean_level;
  logic [fled_pkg::PORT_W-1:0] smoothed_level;
  logic [1:0]                  refuel_event;
  logic [1:0]                  drain_event;
  logic                        refuelling_active;
  logic                        draining_active;

  modport source (
    output valid, output mean_level, output smoothed_level, output refuel_event,
    output drain_event, output refuelling_active, output draining_active,
    input ready
  );
  modport sink (
    input valid, input mean_level, input smoothed_level, input refuel_event,
    input drain_event, input refuelling_active, input draining_active,
    output ready
  );
endinterface

FILE: hw/rtl/fled_cfg_if.sv
// ----------------------------------------------------------------------------
// Fuel level configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fled_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fled_pkg::CFG_IDX_W-1:0] index;
  logic [fled_pkg::PORT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fled_window_avg.sv
// ----------------------------------------------------------------------------
// Fuel level window average
// Sample window with running sum, then a two-stage constant divide that
// forms the window mean with FRAC_W extra fraction bits.
// ----------------------------------------------------------------------------
module fled_window_avg #(
  parameter int unsigned WINDOW     = 5,
  parameter int unsigned LEVEL_BITS = 16,
  parameter int unsigned MW         = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fled_pkg::PORT_W-1:0] level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [MW-1:0]               mean_o
);
  import fled_pkg::*;

  localparam int unsigned SW   = (LEVEL_BITS < PORT_W) ? LEVEL_BITS : PORT_W;
  localparam int unsigned L1   = $clog2(WINDOW);
  localparam int unsigned SUMW = SW + L1;
  localparam int unsigned RW   = (L1 > 0) ? L1 : 1;
  localparam int unsigned N2   = RW + FRAC_W;

  // Round-up reciprocals: floor(x * M / 2^(N+L)) equals floor(x / WINDOW)
  // for every x below 2^N when M = ceil(2^(N+L) / WINDOW).
  localparam int unsigned FW1 = SUMW + L1 + 2;
  localparam logic [FW1-1:0] POW1 = FW1'(1) << (SUMW + L1);
  localparam logic [FW1-1:0] MAG1_FULL = (POW1 + FW1'(WINDOW - 1)) / FW1'(WINDOW);
  localparam logic [SUMW+1:0] MAG1 = MAG1_FULL[SUMW+1:0];

  localparam int unsigned FW2 = N2 + L1 + 2;
  localparam logic [FW2-1:0] POW2 = FW2'(1) << (N2 + L1);
  localparam logic [FW2-1:0] MAG2_FULL = (POW2 + FW2'(WINDOW - 1)) / FW2'(WINDOW);
  localparam logic [N2+1:0] MAG2 = MAG2_FULL[N2+1:0];

  logic [SW-1:0]     taps_q [WINDOW];
  logic [SUMW-1:0]   sum_q;
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic              s2_rdy, s3_rdy;
  logic [SW-1:0]     sample;
  logic [2*SUMW+1:0] prod1;
  logic [SW-1:0]     quo_d;
  logic [SW-1:0]     s2_quo_q;
  logic [SUMW-1:0]   s2_sum_q;
  logic [SUMW-1:0]   rem_full;
  logic [N2-1:0]     frac_num;
  logic [2*N2+1:0]   prod2;
  logic [MW-1:0]     mean_d, mean_q;

  assign s3_rdy     = !s3_v_q || out_ready_i;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign in_ready_o = !s1_v_q || s2_rdy;

  // Bits above LEVEL_BITS are dropped.
  assign sample = level_i[SW-1:0];

  assign prod1 = (2*SUMW+2)'(sum_q) * (2*SUMW+2)'(MAG1);
  assign quo_d = prod1[SUMW+L1 +: SW];

  assign rem_full = s2_sum_q - SUMW'(SUMW'(s2_quo_q) * SUMW'(WINDOW));
  assign frac_num = {rem_full[RW-1:0], {FRAC_W{1'b0}}};
  assign prod2    = (2*N2+2)'(frac_num) * (2*N2+2)'(MAG2);
  assign mean_d   = {s2_quo_q, prod2[N2+L1 +: FRAC_W]};

  // The newest sample enters tap 0 and the oldest falls off the end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        taps_q[i] <= '0;
      end
      sum_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (in_valid_i && in_ready_o) begin
        taps_q[0] <= sample;
        for (int i = 1; i < WINDOW; i++) begin
          taps_q[i] <= taps_q[i-1];
        end
        sum_q <= sum_q + SUMW'(sample) - SUMW'(taps_q[WINDOW-1]);
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_quo_q <= quo_d;
      s2_sum_q <= sum_q;
    end
    if (s3_rdy && s2_v_q) begin
      mean_q <= mean_d;
    end
  end

  assign out_valid_o = s3_v_q;
  assign mean_o      = mean_q;

endmodule

FILE: hw/rtl/fled_smoother.sv
// ----------------------------------------------------------------------------
// Fuel level smoother
// Exponential smoother of period SMOOTH_PERIOD, one update per item.
// ----------------------------------------------------------------------------
module fled_smoother #(
  parameter int unsigned SMOOTH_PERIOD = 50,
  parameter int unsigned MW            = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [MW-1:0] mean_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [MW-1:0] mean_o,
  output logic [MW-1:0] smooth_o
);
  import fled_pkg::*;

  localparam int unsigned N3 = MW + 1;
  localparam int unsigned L3 = $clog2(SMOOTH_PERIOD);
  localparam int unsigned QW = N3 - L3 + 1;
  localparam int unsigned FW3 = N3 + L3 + 2;
  localparam logic [FW3-1:0] POW3 = FW3'(1) << (N3 + L3);
  localparam logic [FW3-1:0] MAG3_FULL =
    (POW3 + FW3'(SMOOTH_PERIOD - 1)) / FW3'(SMOOTH_PERIOD);
  localparam logic [N3+1:0] MAG3 = MAG3_FULL[N3+1:0];

  logic               v_q;
  logic [MW-1:0]      mean_q;
  logic [MW-1:0]      smooth_q, smooth_d;
  logic signed [MW:0] diff;
  logic               neg;
  logic [MW:0]        mag;
  logic [MW:0]        num;
  logic [2*N3+1:0]    prod;
  logic [MW-1:0]      quo;

  assign in_ready_o = !v_q || out_ready_i;

  // (s*(P-1) + m) / P equals s + floor((m - s) / P). A negative difference
  // is rounded toward minus infinity by dividing its magnitude rounded up.
  assign diff = $signed({1'b0, mean_i}) - $signed({1'b0, smooth_q});
  assign neg  = diff[MW];
  assign mag  = neg ? (MW+1)'(-diff) : (MW+1)'(diff);
  assign num  = mag + (neg ? (MW+1)'(SMOOTH_PERIOD - 1) : '0);
  assign prod = (2*N3+2)'(num) * (2*N3+2)'(MAG3);
  assign quo  = MW'(prod[N3+L3 +: QW]);

  always_comb begin
    if (smooth_q == '0) begin
      // An empty smoother is seeded from the mean.
      smooth_d = mean_i;
    end else if (neg) begin
      smooth_d = smooth_q - quo;
    end else begin
      smooth_d = smooth_q + quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= 1'b0;
      smooth_q <= '0;
    end else begin
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
      if (in_valid_i && in_ready_o) begin
        smooth_q <= smooth_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mean_q <= mean_i;
    end
  end

  assign out_valid_o = v_q;
  assign mean_o      = mean_q;
  assign smooth_o    = smooth_q;

endmodule

FILE: hw/rtl/fled_event_track.sv
// ----------------------------------------------------------------------------
// Fuel level event tracker
// Hysteresis compare for refuelling and draining, plus the result register.
// ----------------------------------------------------------------------------
module fled_event_track #(
  parameter int unsigned MW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MW-1:0]     mean_i,
  input  logic [MW-1:0]     smooth_i,
  input  fled_pkg::thresh_t thr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fled_pkg::result_t res_o
);
  import fled_pkg::*;

  typedef struct packed {
    logic   active;
    event_e ev;
  } chan_t;

  function automatic logic signed [CMP_W-1:0] start_level(input logic [PORT_W-1:0] thr);
    return $signed({2'b00, thr, {FRAC_W{1'b0}}});
  endfunction

  function automatic logic signed [CMP_W-1:0] stop_level(input logic [PORT_W-1:0] thr,
                                                         input logic [PORT_W-1:0] hys);
    logic [PORT_W:0] dh;
    dh = {1'b0, thr} - {1'b0, hys};
    return $signed({dh[PORT_W], dh, {FRAC_W{1'b0}}});
  endfunction

  // A clear channel can only begin and a set channel can only end.
  function automatic chan_t track(input logic flag, input logic signed [CMP_W-1:0] diff,
                                  input logic signed [CMP_W-1:0] start,
                                  input logic signed [CMP_W-1:0] stop);
    chan_t c;
    c.active = flag;
    c.ev     = EV_NONE;
    if (!flag && diff >= start) begin
      c.active = 1'b1;
      c.ev     = EV_BEGIN;
    end else if (flag && diff < stop) begin
      c.active = 1'b0;
      c.ev     = EV_END;
    end
    return c;
  endfunction

  logic                    v_q;
  logic                    refuel_q, drain_q;
  logic signed [CMP_W-1:0] rise, fall;
  chan_t                   refuel_d, drain_d;
  event_e                  refuel_ev_q, drain_ev_q;
  logic [PORT_W-1:0]       mean_lvl_q, smooth_lvl_q;

  assign in_ready_o = !v_q || out_ready_i;

  assign rise = CMP_W'($signed({1'b0, mean_i})) - CMP_W'($signed({1'b0, smooth_i}));
  assign fall = -rise;

  assign refuel_d = track(refuel_q, rise, start_level(thr_i.rise_thr),
                          stop_level(thr_i.rise_thr, thr_i.rise_hys));
  assign drain_d  = track(drain_q, fall, start_level(thr_i.fall_thr),
                          stop_level(thr_i.fall_thr, thr_i.fall_hys));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= 1'b0;
      refuel_q <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
      if (in_valid_i && in_ready_o) begin
        refuel_q <= refuel_d.active;
        drain_q  <= drain_d.active;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      refuel_ev_q  <= refuel_d.ev;
      drain_ev_q   <= drain_d.ev;
      mean_lvl_q   <= PORT_W'(mean_i[MW-1:FRAC_W]);
      smooth_lvl_q <= PORT_W'(smooth_i[MW-1:FRAC_W]);
    end
  end

  assign out_valid_o             = v_q;
  assign res_o.mean_level        = mean_lvl_q;
  assign res_o.smoothed_level    = smooth_lvl_q;
  assign res_o.refuel_event      = refuel_ev_q;
  assign res_o.drain_event       = drain_ev_q;
  assign res_o.refuelling_active = refuel_q;
  assign res_o.draining_active   = drain_q;

endmodule

FILE: hw/rtl/fuel_level_event_detector_core.sv
// ----------------------------------------------------------------------------
// Fuel level event detector core
// Window mean, exponential smoothing and refuel/drain hysteresis detection.
// ----------------------------------------------------------------------------
// The block takes one fuel level sample per item and returns one result per
// item, in order. It accepts a new item every clock cycle while results are
// taken. Each item passes five register stages: three for the window sum and
// the mean divide, one for the smoother update and one for the event compare
// and result register. The first stage is loaded at the edge that accepts
// the sample. Every stage holds its item only while the stage after it is
// full, so input ready drops only when all five stages are occupied and the
// result is not being taken. The sustained rate is one item per cycle while
// results are taken; the smoother update, a subtract, one reciprocal multiply
// and an add on one combinational path, sets the clock period.
// Configuration registers may be written at any time the block is idle; the
// configuration channel is always ready and writes to unknown indexes are
// ignored.
module fuel_level_event_detector_core #(
  parameter int unsigned WINDOW        = 5,
  parameter int unsigned SMOOTH_PERIOD = 50,
  parameter int unsigned LEVEL_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fled_in_if.sink   sample_i,
  fled_cfg_if.sink  cfg_i,
  fled_out_if.source result_o
);
  import fled_pkg::*;

  // Sample width after masking, and the width of the mean and smoothed
  // values that carry FRAC_W extra fraction bits.
  localparam int unsigned SW = (LEVEL_BITS < PORT_W) ? LEVEL_BITS : PORT_W;
  localparam int unsigned MW = SW + FRAC_W;

  thresh_t       thr_q;
  logic          avg_valid, avg_ready;
  logic [MW-1:0] avg_mean;
  logic          sm_valid, sm_ready;
  logic [MW-1:0] sm_mean, sm_smooth;
  result_t       res;

  // Configuration registers. Each write goes straight into its register, so
  // the channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.rise_thr <= RISE_THR_RST;
      thr_q.rise_hys <= RISE_HYS_RST;
      thr_q.fall_thr <= FALL_THR_RST;
      thr_q.fall_hys <= FALL_HYS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RISE_THR: thr_q.rise_thr <= cfg_i.data;
        REG_RISE_HYS: thr_q.rise_hys <= cfg_i.data;
        REG_FALL_THR: thr_q.fall_thr <= cfg_i.data;
        REG_FALL_HYS: thr_q.fall_hys <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Window of the last WINDOW samples and their mean.
  fled_window_avg #(
    .WINDOW     (WINDOW),
    .LEVEL_BITS (LEVEL_BITS),
    .MW         (MW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .level_i     (sample_i.tank_level),
    .out_valid_o (avg_valid),
    .out_ready_i (avg_ready),
    .mean_o      (avg_mean)
  );

  // Smoothed level; the state is updated as each mean passes through.
  fled_smoother #(
    .SMOOTH_PERIOD (SMOOTH_PERIOD),
    .MW            (MW)
  ) u_smoother (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (avg_valid),
    .in_ready_o  (avg_ready),
    .mean_i      (avg_mean),
    .out_valid_o (sm_valid),
    .out_ready_i (sm_ready),
    .mean_o      (sm_mean),
    .smooth_o    (sm_smooth)
  );

  // Refuel and drain hysteresis, and the result register.
  fled_event_track #(
    .MW (MW)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sm_valid),
    .in_ready_o  (sm_ready),
    .mean_i      (sm_mean),
    .smooth_i    (sm_smooth),
    .thr_i       (thr_q),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.mean_level        = res.mean_level;
  assign result_o.smoothed_level    = res.smoothed_level;
  assign result_o.refuel_event      = res.refuel_event;
  assign result_o.drain_event       = res.drain_event;
  assign result_o.refuelling_active = res.refuelling_active;
  assign result_o.draining_active   = res.draining_active;

`ifndef SYNTHESIS
  // A begin event always leaves the refuel flag set and an end event clear.
  a_refuel_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.refuel_event != EV_BEGIN || result_o.refuelling_active) &&
      (result_o.refuel_event != EV_END || !result_o.refuelling_active))
    else $error("refuel event code disagrees with refuel flag");

  // The same holds for the drain channel.
  a_drain_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.drain_event != EV_BEGIN || result_o.draining_active) &&
      (result_o.drain_event != EV_END || !result_o.draining_active))
    else $error("drain event code disagrees with drain flag");

  // The input only stalls when the result is waiting and not being taken.
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> result_o.valid && !result_o.ready)
    else $error("input stalled without output backpressure");
`endif

endmodule

FILE: sim/fuel_level_event_detector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuel level event detector core testbench
// Sends fuel level samples through the block under several threshold
// settings, predicts every result from its own model of the window mean,
// the smoother and both hysteresis channels, and checks each result in order.
// ----------------------------------------------------------------------------
module fuel_level_event_detector_core_tb;
  import fled_pkg::*;

  localparam int unsigned WINDOW        = 5;
  localparam int unsigned SMOOTH_PERIOD = 50;
  localparam int unsigned LEVEL_BITS    = 16;

  localparam int unsigned LATENCY     = 5;
  localparam int unsigned DRAIN_WAIT  = 4 * LATENCY;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 45;

  // Register indexes the block has no register for.
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HIGH = 8'hFF;

  // Model of the block: window ring, smoother, both hysteresis channels,
  // and the queue of results it has worked out but not yet seen.
  class level_scoreboard;
    logic [PORT_W-1:0] ring [WINDOW];
    int unsigned       slot;
    logic [63:0]       smooth_fx;
    bit                refuel_on;
    bit                drain_on;
    thresh_t           regs;
    result_t           expected_results [$];
    int unsigned       errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot      = 0;
      smooth_fx = '0;
      refuel_on = 1'b0;
      drain_on  = 1'b0;
      regs      = '{RISE_THR_RST, RISE_HYS_RST, FALL_THR_RST, FALL_HYS_RST};
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PORT_W-1:0] val);
      case (idx)
        REG_RISE_THR: regs.rise_thr = val;
        REG_RISE_HYS: regs.rise_hys = val;
        REG_FALL_THR: regs.fall_thr = val;
        REG_FALL_HYS: regs.fall_hys = val;
        default: ;
      endcase
    endfunction

    // One hysteresis channel. The end level may be negative when the
    // hysteresis exceeds the threshold.
    function event_e track_band(longint diff, logic [PORT_W-1:0] thr,
                                logic [PORT_W-1:0] hys, inout bit on);
      longint thr_l;
      longint hys_l;
      longint start_lvl;
      longint stop_lvl;
      thr_l     = thr;
      hys_l     = hys;
      start_lvl = thr_l * (longint'(1) << FRAC_W);
      stop_lvl  = (thr_l - hys_l) * (longint'(1) << FRAC_W);
      if (!on && diff >= start_lvl) begin
        on = 1'b1;
        return EV_BEGIN;
      end
      if (on && diff < stop_lvl) begin
        on = 1'b0;
        return EV_END;
      end
      return EV_NONE;
    endfunction

    function void note_sample(logic [PORT_W-1:0] lvl);
      logic [63:0] sum;
      logic [63:0] mean_fx;
      longint      rise;
      result_t     res;
      ring[slot] = lvl;
      slot = (slot + 1) % WINDOW;
      sum = '0;
      foreach (ring[i]) sum += ring[i];
      mean_fx = (sum << FRAC_W) / 64'(WINDOW);
      // A smoother at zero is seeded from the mean, as after reset.
      if (smooth_fx == 0) begin
        smooth_fx = mean_fx;
      end else begin
        smooth_fx = (smooth_fx * 64'(SMOOTH_PERIOD - 1) + mean_fx) / 64'(SMOOTH_PERIOD);
      end
      rise = longint'(mean_fx) - longint'(smooth_fx);
      res.refuel_event      = track_band(rise, regs.rise_thr, regs.rise_hys, refuel_on);
      res.drain_event       = track_band(-rise, regs.fall_thr, regs.fall_hys, drain_on);
      res.mean_level        = mean_fx[FRAC_W +: PORT_W];
      res.smoothed_level    = smooth_fx[FRAC_W +: PORT_W];
      res.refuelling_active = refuel_on;
      res.draining_active   = drain_on;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [PORT_W-1:0] want,
                                logic [PORT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no sample waiting: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("mean_level", want.mean_level, got.mean_level);
      compare_field("smoothed_level", want.smoothed_level, got.smoothed_level);
      compare_field("refuel_event", PORT_W'(want.refuel_event),
                    PORT_W'(got.refuel_event));
      compare_field("drain_event", PORT_W'(want.drain_event),
                    PORT_W'(got.drain_event));
      compare_field("refuelling_active", PORT_W'(want.refuelling_active),
                    PORT_W'(got.refuelling_active));
      compare_field("draining_active", PORT_W'(want.draining_active),
                    PORT_W'(got.draining_active));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fled_in_if  sample_bus ();
  fled_cfg_if cfg_bus ();
  fled_out_if result_bus ();

  level_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     cycle_count = 0;
  result_t         seen;

  fuel_level_event_detector_core #(
    .WINDOW       (WINDOW),
    .SMOOTH_PERIOD(SMOOTH_PERIOD),
    .LEVEL_BITS   (LEVEL_BITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_bus),
    .cfg_i   (cfg_bus),
    .result_o(result_bus)
  );

  always #5 clk_i = ~clk_i;

  // The run ends here if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: take results at random and check each one in order.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        seen.mean_level        = result_bus.mean_level;
        seen.smoothed_level    = result_bus.smoothed_level;
        seen.refuel_event      = event_e'(result_bus.refuel_event);
        seen.drain_event       = event_e'(result_bus.drain_event);
        seen.refuelling_active = result_bus.refuelling_active;
        seen.draining_active   = result_bus.draining_active;
        sb.check_result(seen);
      end
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one sample, idling first at the sender's rate, and note it once
  // the block has taken it.
  task automatic send_sample(input logic [PORT_W-1:0] lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.tank_level <= lvl;
    do @(posedge clk_i); while (!(sample_bus.valid && sample_bus.ready));
    sb.note_sample(lvl);
  endtask

  task automatic push_level(input int v);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    send_sample(v[PORT_W-1:0]);
  endtask

  // Configuration valid stays high across back-to-back writes; the caller
  // lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    sb.set_reg(idx, val);
  endtask

  // Waits until every expected result has come out, then lets the
  // pipeline settle before anything else happens.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random part: mostly level traces made of plateaus, refuel steps,
  // drain ramps, slow rises and big drops, with some full-range noise and extremes.
  task automatic run_random(input int unsigned count);
    int unsigned done;
    int          level;
    int          slope;
    int          noise;
    int          seg_len;
    int          kind;
    int          v;
    done  = 0;
    level = $urandom_range(0, 65535);
    while (done < count) begin
      kind    = $urandom_range(0, 9);
      seg_len = $urandom_range(3, 30);
      slope   = 0;
      noise   = $urandom_range(0, 40);
      case (kind)
        0, 1, 2: level = $urandom_range(256, 61440);
        3, 4:    level += int'($urandom_range(200, 8000));
        5, 6:    slope = -int'($urandom_range(1, 300));
        7:       slope = $urandom_range(1, 300);
        8:       level = 0;
        default: level -= int'($urandom_range(200, 8000));
      endcase
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      for (int i = 0; i < seg_len && done < count; i++) begin
        if (kind == 8) begin
          case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(0, 65535);
          endcase
        end else begin
          v = level + int'($urandom_range(0, 2 * noise)) - noise;
        end
        push_level(v);
        level += slope;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        done++;
      end
    end
  endtask

  // Threshold settings, one per phase: moderate, all zero, hysteresis above
  // threshold, top values with no fall hysteresis, wide, and very sensitive.
  thresh_t phase_regs [PHASES];

  initial begin
    phase_regs[0] = '{16'd200, 16'd100, 16'd400, 16'd50};
    phase_regs[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
    phase_regs[2] = '{16'd100, 16'd300, 16'd80, 16'hFFFF};
    phase_regs[3] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
    phase_regs[4] = '{16'd1500, 16'd700, 16'd900, 16'd900};
    phase_regs[5] = '{16'd32, 16'd16, 16'd48, 16'd8};

    sb                    = new();
    rst_ni                = 1'b0;
    send_idle_pct         = 35;
    recv_idle_pct         = 78;
    sample_bus.valid      = 1'b0;
    sample_bus.tank_level = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_RISE_THR;
    cfg_bus.data          = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds first. A single small sample seeds the smoother;
    // the long run of zeros then lets it decay all the way to zero, and
    // the sample after that seeds it again.
    push_level(1);
    repeat (420) push_level(0);
    push_level(300);

    // Directed part: full-scale rise then fall, so both channels begin and
    // end, followed by the extremes and alternating bit patterns.
    repeat (5) push_level(65535);
    repeat (6) push_level(0);
    push_level(43690);
    push_level(21845);
    push_level(32768);
    push_level(32767);
    push_level(65534);
    push_level(1);
    sample_bus.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 78;
      end else if (p < 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Writes to indexes without a register must leave the settings alone.
      write_reg(IDX_UNUSED_LOW, PORT_W'($urandom_range(0, 65535)));
      write_reg(REG_RISE_THR, phase_regs[p].rise_thr);
      write_reg(REG_RISE_HYS, phase_regs[p].rise_hys);
      write_reg(REG_FALL_THR, phase_regs[p].fall_thr);
      write_reg(REG_FALL_HYS, phase_regs[p].fall_hys);
      write_reg(IDX_UNUSED_HIGH, PORT_W'($urandom_range(0, 65535)));
      cfg_bus.valid <= 1'b0;
      @(posedge clk_i);
      run_random(PHASE_ITEMS);
      sample_bus.valid <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
